>>> rtl/plg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_pkg
// shared widths, operation codes and the cordic arctangent table
// ----------------------------------------------------------------------------
package plg_pkg;

  localparam int PATH_DEPTH = 1024;
  localparam int IDX_W      = $clog2(PATH_DEPTH);
  localparam int LEN_W      = IDX_W + 1;
  localparam int POS_W      = 24;
  localparam int YAW_W      = 16;
  localparam int GIDX_W     = 10;
  localparam int LOOK_W     = 20;
  localparam int DIF_W      = POS_W + 1;
  localparam int SQ_W       = 2 * DIF_W;
  localparam int RAD_W      = SQ_W + 2;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int SUM_W      = ROOT_W + LEN_W + 1;
  localparam int WP_W       = 2 * POS_W;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2
  } op_e;

  function automatic logic [31:0] atan_f(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000029;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000003;
      5'd29: r = 32'h00000001;
      5'd30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/plg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module plg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/plg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_sqrt
// bit-serial integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module plg_sqrt import plg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic              done_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int REM_W = ROOT_W + 4;
  localparam int CNT_W = $clog2(ROOT_W);

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q, done_q;
  logic [REM_W-1:0]  rem_n, trial;

  assign rem_n  = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {2'b00, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (rem_n >= trial) begin
        rem_q  <= rem_n - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_n;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> rtl/plg_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_cordic
// iterative vectoring cordic, 32 rotations, binary angle result
// ----------------------------------------------------------------------------
module plg_cordic import plg_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DIF_W-1:0] dx_i,
  input  logic signed [DIF_W-1:0] dy_i,
  output logic                    done_o,
  output logic [YAW_W-1:0]        head_o
);

  localparam int VW = DIF_W + 12;

  logic signed [VW-1:0] x_q, y_q, xs, ys, x0, y0;
  logic [31:0]          acc_q, acc_r;
  logic [4:0]           cnt_q;
  logic                 busy_q, done_q;

  assign x0     = VW'(dx_i) <<< 8;
  assign y0     = VW'(dy_i) <<< 8;
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign acc_r  = acc_q + 32'h0000_8000;
  assign head_o = acc_r[31:16];
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= '0;
        if (dx_i == '0 && dy_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (dx_i < 0) begin
        x_q   <= -x0;
        y_q   <= -y0;
        acc_q <= 32'h8000_0000;
      end else begin
        x_q   <= x0;
        y_q   <= y0;
        acc_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q   <= x_q + ys;
        y_q   <= y_q - xs;
        acc_q <= acc_q + atan_f(cnt_q);
      end else begin
        x_q   <= x_q - ys;
        y_q   <= y_q + xs;
        acc_q <= acc_q - atan_f(cnt_q);
      end
    end
  end

endmodule

>>> rtl/path_lookahead_goal_finder.sv
`timescale 1ns / 1ps
// clear and append complete in idle; a query on an empty path goes straight to the done state
// query: nearest search streams the ram from the search start to the path end, one waypoint a cycle
// walk: each segment is read, differenced, squared and summed, then rooted in the bit-serial square root unit
// heading: computed by the iterative cordic, or taken from the final yaw for the last waypoint
// one item at a time; a query holds off new input until its result is loaded into the output register
// reset clears path length, search start and final yaw, sets lookahead to 512; no ram sweep
// ----------------------------------------------------------------------------
// path_lookahead_goal_finder
// stores a waypoint path in ram and returns the lookahead goal for a pose
// ----------------------------------------------------------------------------
module path_lookahead_goal_finder import plg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // slave side, tdata: pos_x[23:0], pos_y[47:24], yaw[63:48]; tuser: operation
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,
  input  logic [1:0]        s_axis_tuser,
  // master side, tdata: goal_x[23:0], goal_y[47:24], goal_heading[63:48],
  // goal_index[73:64], zero fill; tuser: path_empty
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [79:0]       m_axis_tdata,
  output logic              m_axis_tuser,
  // lookahead distance register
  input  logic              cfg_we_i,
  input  logic [LOOK_W-1:0] cfg_wdata_i
);

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_SEARCH   = 11'b000_0000_0010,
    ST_WALK_RD  = 11'b000_0000_0100,
    ST_WALK_DAT = 11'b000_0000_1000,
    ST_WALK_SQ  = 11'b000_0001_0000,
    ST_WALK_ADD = 11'b000_0010_0000,
    ST_WALK_RT  = 11'b000_0100_0000,
    ST_HEAD_RD  = 11'b000_1000_0000,
    ST_HEAD_DAT = 11'b001_0000_0000,
    ST_HEAD_CO  = 11'b010_0000_0000,
    ST_DONE     = 11'b100_0000_0000
  } state_e;

  state_e state_q;

  // control state
  logic [LEN_W-1:0]  len_q, iss_q, w_q;
  logic [IDX_W-1:0]  start_q;
  logic [YAW_W-1:0]  fyaw_q;
  logic [LOOK_W-1:0] look_q;
  logic              rd_vld_q, a_vld_q, b_vld_q, mvld_q;

  // payload
  logic signed [POS_W-1:0] px_q, py_q, a_x_q, a_y_q, b_x_q, b_y_q, nx_q, ny_q;
  logic signed [POS_W-1:0] prev_x_q, prev_y_q, cx_q, cy_q;
  logic [YAW_W-1:0]        hd_q;
  logic                    empty_q, found_q;
  logic [IDX_W-1:0]        rd_idx_q, a_idx_q, b_idx_q, near_q, goal_q;
  logic signed [DIF_W-1:0] a_dx_q, a_dy_q, w_dx_q, w_dy_q;
  logic [SQ_W-1:0]         b_sqx_q, b_sqy_q, w_sqx_q, w_sqy_q;
  logic [SQ_W:0]           best_q, dsum;
  logic [SUM_W-1:0]        sum_q, sum_n;

  // output register
  logic signed [POS_W-1:0] o_x_q, o_y_q;
  logic [YAW_W-1:0]        o_hd_q;
  logic [GIDX_W-1:0]       o_idx_q;
  logic                    o_empty_q;

  // input word fields
  op_e                     op;
  logic signed [POS_W-1:0] in_x, in_y;
  logic [YAW_W-1:0]        in_yaw;
  logic                    in_acc;

  // ram ports
  logic                    ram_we, ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [WP_W-1:0]         ram_rdata;
  logic signed [POS_W-1:0] rx, ry;

  // datapath units
  logic                    sq_start, sq_done, co_start, co_done;
  logic [ROOT_W-1:0]       sq_root;
  logic [RAD_W-1:0]        sq_rad;
  logic signed [DIF_W-1:0] h_dx, h_dy;
  logic [YAW_W-1:0]        co_head;

  logic [LEN_W-1:0]        gnext;
  logic                    search_re, search_end, walk_more, head_more, out_load;

  assign op     = op_e'(s_axis_tuser);
  assign in_x   = s_axis_tdata[23:0];
  assign in_y   = s_axis_tdata[47:24];
  assign in_yaw = s_axis_tdata[63:48];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // append writes at the current fill level, full path drops the word
  assign ram_we = in_acc && (op == OP_APPEND) && (len_q < LEN_W'(PATH_DEPTH));

  assign gnext      = {1'b0, goal_q} + 1'b1;
  assign search_re  = (iss_q < len_q);
  assign search_end = !search_re && !rd_vld_q && !a_vld_q && !b_vld_q;
  assign walk_more  = (w_q < len_q);
  assign head_more  = (gnext < len_q);

  // one read port shared by search, walk and heading fetch
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = iss_q[IDX_W-1:0];
    case (state_q)
      ST_SEARCH: begin
        ram_re    = search_re;
        ram_raddr = iss_q[IDX_W-1:0];
      end
      ST_WALK_RD: begin
        ram_re    = walk_more;
        ram_raddr = w_q[IDX_W-1:0];
      end
      ST_HEAD_RD: begin
        ram_re    = head_more;
        ram_raddr = gnext[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  plg_ram #(
    .WIDTH (WP_W),
    .DEPTH (PATH_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (len_q[IDX_W-1:0]),
    .wdata_i ({in_y, in_x}),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rx = ram_rdata[POS_W-1:0];
  assign ry = ram_rdata[WP_W-1:POS_W];

  // squared distance of the search stage entering the compare
  assign dsum = {1'b0, b_sqx_q} + {1'b0, b_sqy_q};

  // segment length
  assign sq_start = (state_q == ST_WALK_ADD);
  assign sq_rad   = RAD_W'({1'b0, w_sqx_q} + {1'b0, w_sqy_q});
  assign sum_n    = sum_q + SUM_W'(sq_root);

  plg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // heading toward the waypoint after the goal
  assign co_start = (state_q == ST_HEAD_DAT);
  assign h_dx     = DIF_W'(rx) - DIF_W'(prev_x_q);
  assign h_dy     = DIF_W'(ry) - DIF_W'(prev_y_q);

  plg_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (co_start),
    .dx_i    (h_dx),
    .dy_i    (h_dy),
    .done_o  (co_done),
    .head_o  (co_head)
  );

  assign out_load = (state_q == ST_DONE) && (!mvld_q || m_axis_tready);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      len_q    <= '0;
      iss_q    <= '0;
      w_q      <= '0;
      start_q  <= '0;
      fyaw_q   <= '0;
      look_q   <= LOOK_W'(512);
      rd_vld_q <= 1'b0;
      a_vld_q  <= 1'b0;
      b_vld_q  <= 1'b0;
      mvld_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        look_q <= cfg_wdata_i;
      end
      rd_vld_q <= (state_q == ST_SEARCH) && search_re;
      a_vld_q  <= rd_vld_q;
      b_vld_q  <= a_vld_q;
      if (out_load) begin
        mvld_q <= 1'b1;
      end else if (m_axis_tready) begin
        mvld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            case (op)
              OP_CLEAR: begin
                len_q   <= '0;
                start_q <= '0;
                fyaw_q  <= '0;
              end
              OP_APPEND: begin
                if (ram_we) begin
                  len_q  <= len_q + 1'b1;
                  fyaw_q <= in_yaw;
                end
              end
              OP_QUERY: begin
                if (len_q == '0) begin
                  state_q <= ST_DONE;
                end else begin
                  // stale start index falls back to the path head
                  iss_q   <= ({1'b0, start_q} >= len_q) ? '0 : {1'b0, start_q};
                  state_q <= ST_SEARCH;
                end
              end
              default: ;
            endcase
          end
        end
        ST_SEARCH: begin
          if (search_re) begin
            iss_q <= iss_q + 1'b1;
          end
          if (search_end) begin
            start_q <= near_q;
            w_q     <= {1'b0, near_q} + 1'b1;
            state_q <= ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          state_q <= walk_more ? ST_WALK_DAT : ST_HEAD_RD;
        end
        ST_WALK_DAT: state_q <= ST_WALK_SQ;
        ST_WALK_SQ:  state_q <= ST_WALK_ADD;
        ST_WALK_ADD: state_q <= ST_WALK_RT;
        ST_WALK_RT: begin
          if (sq_done) begin
            w_q     <= w_q + 1'b1;
            state_q <= (sum_n >= SUM_W'(look_q)) ? ST_HEAD_RD : ST_WALK_RD;
          end
        end
        ST_HEAD_RD: begin
          state_q <= head_more ? ST_HEAD_DAT : ST_DONE;
        end
        ST_HEAD_DAT: state_q <= ST_HEAD_CO;
        ST_HEAD_CO: begin
          if (co_done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rd_idx_q <= iss_q[IDX_W-1:0];

    // search pipe: difference, squares, compare
    a_idx_q <= rd_idx_q;
    a_x_q   <= rx;
    a_y_q   <= ry;
    a_dx_q  <= DIF_W'(rx) - DIF_W'(px_q);
    a_dy_q  <= DIF_W'(ry) - DIF_W'(py_q);
    b_idx_q <= a_idx_q;
    b_x_q   <= a_x_q;
    b_y_q   <= a_y_q;
    b_sqx_q <= $unsigned(SQ_W'(a_dx_q) * SQ_W'(a_dx_q));
    b_sqy_q <= $unsigned(SQ_W'(a_dy_q) * SQ_W'(a_dy_q));

    if (b_vld_q && (!found_q || dsum < best_q)) begin
      best_q  <= dsum;
      near_q  <= b_idx_q;
      nx_q    <= b_x_q;
      ny_q    <= b_y_q;
      found_q <= 1'b1;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc && op == OP_QUERY) begin
          px_q    <= in_x;
          py_q    <= in_y;
          hd_q    <= in_yaw;
          empty_q <= (len_q == '0);
          found_q <= 1'b0;
        end
      end
      ST_SEARCH: begin
        if (search_end) begin
          sum_q    <= '0;
          goal_q   <= near_q;
          prev_x_q <= nx_q;
          prev_y_q <= ny_q;
        end
      end
      ST_WALK_DAT: begin
        w_dx_q <= DIF_W'(rx) - DIF_W'(prev_x_q);
        w_dy_q <= DIF_W'(ry) - DIF_W'(prev_y_q);
        cx_q   <= rx;
        cy_q   <= ry;
      end
      ST_WALK_SQ: begin
        w_sqx_q <= $unsigned(SQ_W'(w_dx_q) * SQ_W'(w_dx_q));
        w_sqy_q <= $unsigned(SQ_W'(w_dy_q) * SQ_W'(w_dy_q));
      end
      ST_WALK_RT: begin
        if (sq_done) begin
          sum_q    <= sum_n;
          goal_q   <= w_q[IDX_W-1:0];
          prev_x_q <= cx_q;
          prev_y_q <= cy_q;
        end
      end
      ST_HEAD_RD: begin
        // last waypoint keeps the final yaw
        if (!head_more) begin
          hd_q <= fyaw_q;
        end
      end
      ST_HEAD_CO: begin
        if (co_done) begin
          hd_q <= co_head;
        end
      end
      default: ;
    endcase

    if (out_load) begin
      o_x_q     <= empty_q ? px_q : prev_x_q;
      o_y_q     <= empty_q ? py_q : prev_y_q;
      o_hd_q    <= hd_q;
      o_idx_q   <= empty_q ? '0 : GIDX_W'(goal_q);
      o_empty_q <= empty_q;
    end
  end

  assign m_axis_tvalid = mvld_q;
  assign m_axis_tdata  = {6'b0, o_idx_q, o_hd_q, o_y_q, o_x_q};
  assign m_axis_tuser  = o_empty_q;

endmodule

>>> rtl/plg_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plg_checker
// port level checks on the goal finder, bound to the top level
// ----------------------------------------------------------------------------
module plg_checker import plg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic [1:0]        s_axis_tuser,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [79:0]       m_axis_tdata,
  input logic              m_axis_tuser
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("result word changed while stalled");

  // empty path answer carries index zero
  a_empty_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[73:64] == '0)
    else $error("empty path result with nonzero index");

  // clear with nothing pending gives no result
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser == OP_CLEAR && !m_axis_tvalid
      |=> !m_axis_tvalid)
    else $error("result after clear");

  // no new word taken while a result is loaded into an idle output
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared while input was being taken");

endmodule

bind path_lookahead_goal_finder plg_checker u_plg_checker (.*);
